>>> rtl/core/pnghdr_pkg.sv
// shared types, codes and signature tables for the png header parser
package pnghdr_pkg;

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TAG  = 3'd2;
  localparam logic [2:0] PH_WID  = 3'd3;
  localparam logic [2:0] PH_HGT  = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_BADSIG = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;
  localparam logic [1:0] ST_NOTFND = 2'd3;

  localparam logic [31:0] TAG_IHDR   = 32'h4948_4452;
  localparam logic [31:0] IHDR_LEN   = 32'd13;
  localparam logic [3:0]  WORD_BYTES = 4'd4;
  localparam logic [2:0]  SIG_LAST   = 3'd7;
  localparam logic [32:0] CRC_BYTES  = 33'd4;

  // bit 0: png still possible, bit 1: mng still possible
  localparam logic [1:0] SIG_BOTH = 2'b11;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  byte_count;
    logic [1:0]  sig_match;
    logic [31:0] chunk_length;
    logic [31:0] chunk_tag;
    logic [32:0] skip_remaining;
    logic [31:0] width_acc;
    logic [31:0] height_acc;
  } pnghdr_state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [31:0] width;
    logic [31:0] height;
  } pnghdr_result_t;

  localparam pnghdr_state_t STATE_RESET = '{
    phase:          PH_SIG,
    byte_count:     4'd0,
    sig_match:      SIG_BOTH,
    chunk_length:   32'd0,
    chunk_tag:      32'd0,
    skip_remaining: 33'd0,
    width_acc:      32'd0,
    height_acc:     32'd0
  };

  function automatic logic [7:0] sig_png_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4e;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0d;
      3'd5: b = 8'h0a;
      3'd6: b = 8'h1a;
      3'd7: b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] sig_mng_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h8a;
      3'd1: b = 8'h4d;
      3'd2: b = 8'h4e;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0d;
      3'd5: b = 8'h0a;
      3'd6: b = 8'h1a;
      3'd7: b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/pnghdr_step.sv
// per-byte next-state and result logic of the png header parser
module pnghdr_step (
  input  pnghdr_pkg::pnghdr_state_t  state_i,
  input  logic [7:0]                 data_byte,
  input  logic                       last_byte,
  output pnghdr_pkg::pnghdr_state_t  state_nxt,
  output pnghdr_pkg::pnghdr_result_t result
);
  import pnghdr_pkg::*;

  logic [2:0]  sig_idx;
  logic [1:0]  match_nxt;
  logic [3:0]  cnt_inc;
  logic [31:0] len_shift;
  logic [31:0] tag_shift;
  logic [31:0] wid_shift;
  logic [31:0] hgt_shift;
  logic [32:0] skip_dec;

  assign sig_idx   = state_i.byte_count[2:0];
  assign match_nxt = state_i.sig_match &
                     {data_byte == sig_mng_byte(sig_idx), data_byte == sig_png_byte(sig_idx)};
  assign cnt_inc   = state_i.byte_count + 4'd1;
  assign len_shift = {state_i.chunk_length[23:0], data_byte};
  assign tag_shift = {state_i.chunk_tag[23:0], data_byte};
  assign wid_shift = {state_i.width_acc[23:0], data_byte};
  assign hgt_shift = {state_i.height_acc[23:0], data_byte};
  assign skip_dec  = (state_i.skip_remaining != 33'd0) ?
                     state_i.skip_remaining - 33'd1 : state_i.skip_remaining;

  always_comb begin
    state_nxt     = state_i;
    result.valid  = 1'b0;
    result.status = ST_NOTFND;
    result.width  = 32'd0;
    result.height = 32'd0;

    unique case (state_i.phase)
      PH_SIG: begin
        state_nxt.sig_match = match_nxt;
        if (match_nxt == 2'b00) begin
          result.valid  = 1'b1;
          result.status = ST_BADSIG;
        end else if (sig_idx == SIG_LAST) begin
          state_nxt.phase        = PH_LEN;
          state_nxt.byte_count   = 4'd0;
          state_nxt.chunk_length = 32'd0;
          if (last_byte) begin
            result.valid  = 1'b1;
            result.status = ST_NOTFND;
          end
        end else begin
          state_nxt.byte_count = {1'b0, sig_idx + 3'd1};
          if (last_byte) begin
            result.valid  = 1'b1;
            result.status = ST_BADSIG;
          end
        end
      end
      PH_LEN: begin
        state_nxt.chunk_length = len_shift;
        state_nxt.byte_count   = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          state_nxt.phase      = PH_TAG;
          state_nxt.byte_count = 4'd0;
          state_nxt.chunk_tag  = 32'd0;
        end
        if (last_byte) begin
          result.valid  = 1'b1;
          result.status = ST_NOTFND;
        end
      end
      PH_TAG: begin
        state_nxt.chunk_tag  = tag_shift;
        state_nxt.byte_count = cnt_inc;
        if (last_byte) begin
          result.valid  = 1'b1;
          result.status = ST_NOTFND;
        end
        if (cnt_inc >= WORD_BYTES) begin
          state_nxt.byte_count = 4'd0;
          if (tag_shift == TAG_IHDR) begin
            if (state_i.chunk_length != IHDR_LEN) begin
              // a bad length on the final byte still reads as not found
              result.valid  = 1'b1;
              result.status = last_byte ? ST_NOTFND : ST_BADLEN;
            end else begin
              state_nxt.phase     = PH_WID;
              state_nxt.width_acc = 32'd0;
            end
          end else begin
            state_nxt.phase          = PH_SKIP;
            state_nxt.skip_remaining = {1'b0, state_i.chunk_length} + CRC_BYTES;
          end
        end
      end
      PH_WID: begin
        state_nxt.width_acc  = wid_shift;
        state_nxt.byte_count = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          state_nxt.phase      = PH_HGT;
          state_nxt.byte_count = 4'd0;
          state_nxt.height_acc = 32'd0;
        end
        if (last_byte) begin
          result.valid  = 1'b1;
          result.status = ST_NOTFND;
        end
      end
      PH_HGT: begin
        state_nxt.height_acc = hgt_shift;
        state_nxt.byte_count = cnt_inc;
        if (cnt_inc >= WORD_BYTES) begin
          result.valid  = 1'b1;
          result.status = ST_FOUND;
          result.width  = state_i.width_acc;
          result.height = hgt_shift;
        end else if (last_byte) begin
          result.valid  = 1'b1;
          result.status = ST_NOTFND;
        end
      end
      PH_SKIP: begin
        state_nxt.skip_remaining = skip_dec;
        if (skip_dec == 33'd0) begin
          state_nxt.phase        = PH_LEN;
          state_nxt.byte_count   = 4'd0;
          state_nxt.chunk_length = 32'd0;
        end
        if (last_byte) begin
          result.valid  = 1'b1;
          result.status = ST_NOTFND;
        end
      end
      default: begin
        // done: swallow bytes until the end mark
      end
    endcase

    if (last_byte) begin
      state_nxt = STATE_RESET;
    end else if (result.valid) begin
      state_nxt.phase = PH_DONE;
    end
  end

endmodule

>>> rtl/core/png_header_dimension_parser_core.sv
// top level of the streaming png/mng header dimension parser
// Usage:
//   in_*  : one file byte per request (in_data_byte) with in_last_byte set on
//           the final byte of the file; valid/ready handshake.
//   out_* : at most one result per file: out_status (found, bad signature,
//           bad ihdr length, not found) with out_width/out_height from the
//           ihdr chunk, zero unless found; valid/ready handshake.
// Timing:
//   a byte is taken into an input register at the request edge and parsed
//   there while the output register is free; a result, if any, is then
//   registered in the output register, which drives out_valid. One byte per
//   cycle is sustained while no result waits on out_ready; the rate is set
//   by the single parse stage between the input and output registers.
// Reset:
//   rst_n low clears both register stages and returns the parser to the
//   signature phase. The parser also rearms itself after every end mark.
// Stall:
//   while a result waits on out_ready the parse stage holds its byte; the
//   input register still fills once, then in_ready drops until the result
//   is taken.
module png_header_dimension_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_width,
  output logic [31:0] out_height
);
  import pnghdr_pkg::*;

  logic           s1_valid_r;
  logic [7:0]     s1_byte_r;
  logic           s1_last_r;
  logic           s1_fire;
  logic           out_free;
  pnghdr_state_t  st_r;
  pnghdr_state_t  st_nxt;
  pnghdr_result_t res;
  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [31:0]    out_width_r;
  logic [31:0]    out_height_r;

  pnghdr_step u_step (
    .state_i   (st_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .state_nxt (st_nxt),
    .result    (res)
  );

  // the parse stage moves only when the output register can take a result
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      out_status_r <= res.status;
      out_width_r  <= res.width;
      out_height_r <= res.height;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_width  = out_width_r;
  assign out_height = out_height_r;

`ifndef SYNTHESIS
  a_dims_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_FOUND) |-> (out_width_r == 32'd0) && (out_height_r == 32'd0))
    else $error("dimensions nonzero on a result other than found");

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res.valid && !s1_last_r |=> st_r.phase == PH_DONE)
    else $error("parser not parked after a result");

  a_rearm_on_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> (st_r.phase == PH_SIG) && (st_r.byte_count == 4'd0))
    else $error("parser did not rearm after the end mark");

  a_no_result_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_DONE) |-> !res.valid)
    else $error("result raised while parked");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free stage");
`endif

endmodule

>>> sim/png_header_dimension_parser_core_test.sv
// testbench for the png/mng header dimension parser: directed files, random files, scoreboard
module png_header_dimension_parser_core_test;
  import pnghdr_pkg::*;

  localparam logic [63:0] PNG_MAGIC   = 64'h8950_4e47_0d0a_1a0a;
  localparam logic [63:0] MNG_MAGIC   = 64'h8a4d_4e47_0d0a_1a0a;
  localparam logic [31:0] TAG_IDAT    = "IDAT";
  localparam logic [31:0] TAG_TEXT    = "tEXt";
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_BYTES = 740;
  localparam int          MIN_FILES   = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] w;
    logic [31:0] h;
  } dims_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_width;
  logic [31:0] out_height;

  // predicted parser state
  logic [2:0]  p_phase;
  logic [3:0]  p_pos;
  logic [1:0]  p_alive;
  logic [31:0] p_len;
  logic [31:0] p_tag;
  logic [32:0] p_skip;
  logic [31:0] p_wid;
  logic [31:0] p_hgt;

  dims_t       dims_due[$];
  dims_t       dims_head;
  logic [7:0]  file_bytes[$];

  int src_gap_max = 8;
  int sink_gap_max = 8;
  int err_count = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  png_header_dimension_parser_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_width    (out_width),
    .out_height   (out_height)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, dims_due.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= 100) begin
      $display("[%0t] %s: got %h want %h", $time, what, got, want);
    end
  endtask

  task automatic ihdr_clear();
    p_phase = PH_SIG;
    p_pos   = 4'd0;
    p_alive = 2'b11;
    p_len   = 32'd0;
    p_tag   = 32'd0;
    p_skip  = 33'd0;
    p_wid   = 32'd0;
    p_hgt   = 32'd0;
  endtask

  // advance the predicted parser by one byte, queue the result it gives
  task automatic ihdr_predict_byte(input logic [7:0] b, input logic last);
    int         k;
    logic       hit;
    logic [1:0] code;
    dims_t      res;
    hit  = 1'b0;
    code = ST_NOTFND;
    case (p_phase)
      PH_SIG: begin
        k = 56 - 8 * int'(p_pos[2:0]);
        if (b != PNG_MAGIC[k +: 8]) p_alive[0] = 1'b0;
        if (b != MNG_MAGIC[k +: 8]) p_alive[1] = 1'b0;
        if (p_alive == 2'b00) begin
          hit  = 1'b1;
          code = ST_BADSIG;
        end else if (p_pos[2:0] == SIG_LAST) begin
          p_phase = PH_LEN;
          p_pos   = 4'd0;
          p_len   = 32'd0;
          hit     = last;
        end else begin
          p_pos = {1'b0, p_pos[2:0]} + 4'd1;
          if (last) begin
            hit  = 1'b1;
            code = ST_BADSIG;
          end
        end
      end
      PH_LEN: begin
        p_len = {p_len[23:0], b};
        p_pos = p_pos + 4'd1;
        if (p_pos >= WORD_BYTES) begin
          p_phase = PH_TAG;
          p_pos   = 4'd0;
          p_tag   = 32'd0;
        end
        hit = last;
      end
      PH_TAG: begin
        p_tag = {p_tag[23:0], b};
        p_pos = p_pos + 4'd1;
        if (p_pos >= WORD_BYTES) begin
          p_pos = 4'd0;
          if (p_tag == TAG_IHDR) begin
            // a wrong length on the file's final byte reads as not found
            if (p_len != IHDR_LEN) begin
              hit  = 1'b1;
              code = last ? ST_NOTFND : ST_BADLEN;
            end else begin
              p_phase = PH_WID;
              p_wid   = 32'd0;
            end
          end else begin
            p_phase = PH_SKIP;
            p_skip  = {1'b0, p_len} + CRC_BYTES;
          end
        end
        hit = hit | last;
      end
      PH_WID: begin
        p_wid = {p_wid[23:0], b};
        p_pos = p_pos + 4'd1;
        if (p_pos >= WORD_BYTES) begin
          p_phase = PH_HGT;
          p_pos   = 4'd0;
          p_hgt   = 32'd0;
        end
        hit = last;
      end
      PH_HGT: begin
        p_hgt = {p_hgt[23:0], b};
        p_pos = p_pos + 4'd1;
        if (p_pos >= WORD_BYTES) begin
          hit  = 1'b1;
          code = ST_FOUND;
        end else begin
          hit = last;
        end
      end
      PH_SKIP: begin
        if (p_skip != 33'd0) p_skip = p_skip - 33'd1;
        if (p_skip == 33'd0) begin
          p_phase = PH_LEN;
          p_pos   = 4'd0;
          p_len   = 32'd0;
        end
        hit = last;
      end
      default: ;
    endcase
    if (hit) begin
      res.status = code;
      res.w      = (code == ST_FOUND) ? p_wid : 32'd0;
      res.h      = (code == ST_FOUND) ? p_hgt : 32'd0;
      dims_due.push_back(res);
    end
    if (last) ihdr_clear();
    else if (hit) p_phase = PH_DONE;
  endtask

  // one byte request: random gap, then hold until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ihdr_predict_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_file();
    int n;
    n = file_bytes.size();
    for (int i = 0; i < n; i++) send_byte(file_bytes[i], i == n - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic add_sig(input logic mng);
    add_word(mng ? MNG_MAGIC[63:32] : PNG_MAGIC[63:32]);
    add_word(mng ? MNG_MAGIC[31:0] : PNG_MAGIC[31:0]);
  endtask

  task automatic add_noise(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle();
    in_valid <= 1'b0;
    while (dims_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // result side: random stall before each result, then take it
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      status_seen[out_status]++;
      if (dims_due.size() == 0) begin
        report_mismatch("result with nothing expected", {30'd0, out_status}, 32'd0);
      end else begin
        dims_head = dims_due.pop_front();
        if (out_status !== dims_head.status)
          report_mismatch("status", {30'd0, out_status}, {30'd0, dims_head.status});
        if (out_width !== dims_head.w) report_mismatch("width", out_width, dims_head.w);
        if (out_height !== dims_head.h) report_mismatch("height", out_height, dims_head.h);
      end
    end
  end

  task automatic test_signature_cases();
    // mismatch on the very first byte, which is also the end mark
    file_bytes.push_back(8'h00);
    send_file();
    // mismatch mid-signature, following bytes ignored
    file_bytes = '{8'h89, 8'h50, 8'h4e, 8'h00, 8'h11, 8'hff};
    send_file();
    // file shorter than the signature
    file_bytes = '{8'h8a, 8'h4d};
    send_file();
    // full signature and nothing else
    add_sig(1'b0);
    send_file();
  endtask

  task automatic test_ihdr_cases();
    add_sig(1'b0);
    add_word(IHDR_LEN);
    add_word(TAG_IHDR);
    add_word(32'hffff_ffff);
    add_word(32'h0000_0000);
    add_noise(3);
    send_file();
    // skipped empty chunk, then ihdr with the result on the end mark
    add_sig(1'b1);
    add_word(32'd0);
    add_word(TAG_TEXT);
    add_noise(4);
    add_word(IHDR_LEN);
    add_word(TAG_IHDR);
    add_word(32'h0000_0000);
    add_word(32'hffff_ffff);
    send_file();
    add_sig(1'b0);
    add_word(32'd12);
    add_word(TAG_IHDR);
    add_noise(2);
    send_file();
    // bad length decided on the final byte
    add_sig(1'b0);
    add_word(32'hffff_ffff);
    add_word(TAG_IHDR);
    send_file();
    // cut off inside the width
    add_sig(1'b1);
    add_word(IHDR_LEN);
    add_word(TAG_IHDR);
    add_noise(2);
    send_file();
    // huge chunk that cannot be skipped before the end
    add_sig(1'b0);
    add_word(32'hffff_ffff);
    add_word(TAG_IDAT);
    add_noise(5);
    send_file();
    // end inside the length word
    add_sig(1'b0);
    add_noise(2);
    send_file();
  endtask

  task automatic test_drain_pause();
    add_sig(1'b0);
    add_word(IHDR_LEN);
    add_word(TAG_IHDR);
    add_word(32'd640);
    add_word(32'd480);
    send_file();
    settle();
    // back to back right after the pause
    src_gap_max  = 0;
    sink_gap_max = 0;
    add_sig(1'b1);
    add_word(IHDR_LEN);
    add_word(TAG_IHDR);
    add_word(32'h1234_5678);
    add_word(32'h9abc_def0);
    add_noise(1);
    send_file();
    src_gap_max  = 8;
    sink_gap_max = 8;
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return 32'hffff_ffff;
      2:       return 32'($urandom_range(1, 4096));
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed files with random content, some noise and broken ones
  task automatic build_random_file();
    int          kind;
    int          chunks;
    int          keep;
    logic        huge;
    logic [31:0] len;
    kind = $urandom_range(0, 99);
    huge = 1'b0;
    if (kind < 8) begin
      add_noise($urandom_range(1, 12));
      return;
    end
    add_sig(1'($urandom_range(0, 1)));
    if (kind < 18) begin
      keep = $urandom_range(0, 7);
      file_bytes[keep] = file_bytes[keep] ^ (8'd1 << $urandom_range(0, 7));
    end
    chunks = $urandom_range(0, 2);
    for (int c = 0; c < chunks && !huge; c++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_word($urandom);
        add_word($urandom);
        add_noise($urandom_range(0, 6));
        huge = 1'b1;
      end else begin
        len = $urandom_range(0, 5);
        add_word(len);
        add_word($urandom);
        add_noise(len + 4);
      end
    end
    if (!huge) begin
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(0, 1) ? $urandom : (IHDR_LEN ^ (32'd1 << $urandom_range(0, 31)));
      end else begin
        len = IHDR_LEN;
      end
      add_word(len);
      add_word(TAG_IHDR);
      add_word(pick_dim());
      add_word(pick_dim());
      add_noise($urandom_range(0, 4));
    end
    if ($urandom_range(0, 4) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    end
  endtask

  task automatic test_random_files();
    int start_bytes;
    int start_files;
    start_bytes = bytes_sent;
    start_files = files_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES || files_sent - start_files < MIN_FILES) begin
      if ((files_sent - start_files) % 10 == 0) begin
        case ($urandom_range(0, 3))
          0:       src_gap_max = 0;
          1:       src_gap_max = 2;
          default: src_gap_max = 8;
        endcase
        case ($urandom_range(0, 3))
          0:       sink_gap_max = 0;
          1:       sink_gap_max = 2;
          default: sink_gap_max = 8;
        endcase
      end
      build_random_file();
      send_file();
      if ((files_sent - start_files) % 17 == 0) settle();
    end
  endtask

  initial begin
    ihdr_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_signature_cases();
    test_ihdr_cases();
    test_drain_pause();
    test_random_files();
    settle();
    $display("%0d bytes in %0d files, both sides idling at random", bytes_sent, files_sent);
    $display("results: found %0d, bad signature %0d, bad ihdr length %0d, not found %0d",
             status_seen[ST_FOUND], status_seen[ST_BADSIG], status_seen[ST_BADLEN],
             status_seen[ST_NOTFND]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
